/* rtl/spc_pkg.sv */
// Shared constants, register codes and types of the slab particle classifier.
// No dependencies; every other file of the block imports this package.
package spc_pkg;

	localparam int MAX_SLABS_DEF  = 256;
	localparam int COORD_BITS_DEF = 32;

	localparam int AXIS_W    = 2;
	localparam int SW_W      = 31;
	localparam int GW_W      = 31;
	localparam int RK_W      = 8;
	localparam int CNT_W     = 9;
	localparam int OWN_W     = 8;
	localparam int PROD_W    = CNT_W + SW_W;
	localparam int NUM_REGS  = 7;
	localparam int REG_IDX_W = $clog2(NUM_REGS);

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

	localparam logic [REG_IDX_W-1:0] REG_SPLIT_AXIS  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AXIS_MIN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AXIS_MAX    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLAB_WIDTH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RANK_INDEX  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RANK_COUNT  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_GHOST_WIDTH = 3'd6;

	localparam int                AXIS_MAX_RST   = 65536;
	localparam logic [SW_W-1:0]   SLAB_WIDTH_RST = 31'd65536;
	localparam logic [CNT_W-1:0]  RANK_COUNT_RST = 9'd1;

	typedef struct packed {
		logic outside;
		logic clamp;
		logic is_local;
		logic in_lower_ghost;
		logic in_upper_ghost;
		logic send_lower;
		logic send_upper;
	} cls_flags_t;

	typedef struct packed {
		logic has_lower;
		logic has_upper;
	} nbr_t;

endpackage

/* rtl/spc_ifs.sv */
// Stream interfaces of the classifier: position beats in, result beats out.
// Depends on spc_pkg for field widths.
interface spc_pos_if #(parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface spc_res_if;
	import spc_pkg::*;
	logic             valid;
	logic             ready;
	logic [OWN_W-1:0] owner_slab;
	logic             outside_domain;
	logic             is_local;
	logic             in_lower_ghost;
	logic             in_upper_ghost;
	logic             send_lower;
	logic             send_upper;

	modport source (output valid, output owner_slab, output outside_domain, output is_local,
		output in_lower_ghost, output in_upper_ghost, output send_lower, output send_upper,
		input ready);
	modport sink (input valid, input owner_slab, input outside_domain, input is_local,
		input in_lower_ghost, input in_upper_ghost, input send_lower, input send_upper,
		output ready);
endinterface

/* rtl/slab_particle_classifier_unit.sv */
// Top level of the slab particle classifier: register port, bounds, front
// pipeline, division cell chain and result register. Uses spc_pkg and spc_ifs.
//
// One position beat is taken per clock while no stall holds the pipe, and each
// yields one result beat (QB = log2 of the slab limit): three front stages
// select the axis, test the domain and compare against the slab and ghost
// bounds, then a row of QB cells settles the owner slab one quotient bit per
// cell, and a result register holds the beat for the sink. Every stage has its
// own valid bit, so beats keep entering while a result is stalled until the
// pipe is full. After a register write the derived bounds pass through the
// product and bound registers and are read from the third front stage on, so
// a beat may follow a write at once. Write registers only while no beat is in
// flight. There is no memory and no clearing pass after reset.
module slab_particle_classifier_unit #(
	parameter int  MAX_SLABS  = spc_pkg::MAX_SLABS_DEF,
	parameter int  COORD_BITS = spc_pkg::COORD_BITS_DEF,
	localparam int DATA_W     = (COORD_BITS > 32) ? 64 : 32,
	localparam int STRIDE_LOG = (COORD_BITS > 32) ? 3 : 2,
	localparam int ADDR_W     = STRIDE_LOG + spc_pkg::REG_IDX_W
) (
	input  logic              clk,
	input  logic              arst_n,
	spc_pos_if.sink           pos_in,
	spc_res_if.source         res_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);
	import spc_pkg::*;

	localparam int CB      = COORD_BITS;
	localparam int CNT_MAX = (MAX_SLABS < 511) ? MAX_SLABS : 511;
	localparam int QB      = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
	localparam int WB      = ((CB > PROD_W) ? CB : PROD_W) + 3;
	localparam int DW      = ((CB > SW_W + QB) ? CB : SW_W + QB) + 1;

	logic [AXIS_W-1:0]    split_axis_q;
	logic [CB-1:0]        axis_min_q;
	logic [CB-1:0]        axis_max_q;
	logic [SW_W-1:0]      slab_width_q;
	logic [RK_W-1:0]      rank_index_q;
	logic [CNT_W-1:0]     rank_count_q;
	logic [GW_W-1:0]      ghost_width_q;

	logic                 wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [SW_W-1:0]      w_eff;

	logic signed [WB-1:0] lo, hi;
	logic [PROD_W-1:0]    cntw;
	logic [QB-1:0]        cntm1;
	nbr_t                 nbr;

	logic                 v_c     [QB+1];
	logic                 r_c     [QB+1];
	logic [DW-1:0]        rem_c   [QB+1];
	logic [QB-1:0]        quo_c   [QB+1];
	cls_flags_t           flags_c [QB+1];
	logic [CB-1:0]        diff;

	logic                 res_valid_q;
	logic                 res_rdy;
	logic [QB-1:0]        owner_sel;
	logic [QB+OWN_W-1:0]  owner_ext;
	logic [OWN_W-1:0]     owner_q;
	cls_flags_t           res_flags_q;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:STRIDE_LOG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_axis_q  <= AXIS_X;
			axis_min_q    <= '0;
			axis_max_q    <= CB'(AXIS_MAX_RST);
			slab_width_q  <= SLAB_WIDTH_RST;
			rank_index_q  <= '0;
			rank_count_q  <= RANK_COUNT_RST;
			ghost_width_q <= '0;
		end else if (wr) begin
			unique case (reg_idx)
				REG_SPLIT_AXIS:  split_axis_q  <= pwdata[AXIS_W-1:0];
				REG_AXIS_MIN:    axis_min_q    <= pwdata[CB-1:0];
				REG_AXIS_MAX:    axis_max_q    <= pwdata[CB-1:0];
				REG_SLAB_WIDTH:  slab_width_q  <= pwdata[SW_W-1:0];
				REG_RANK_INDEX:  rank_index_q  <= pwdata[RK_W-1:0];
				REG_RANK_COUNT:  rank_count_q  <= pwdata[CNT_W-1:0];
				REG_GHOST_WIDTH: ghost_width_q <= pwdata[GW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SPLIT_AXIS:  prdata = DATA_W'(split_axis_q);
			REG_AXIS_MIN:    prdata = DATA_W'(axis_min_q);
			REG_AXIS_MAX:    prdata = DATA_W'(axis_max_q);
			REG_SLAB_WIDTH:  prdata = DATA_W'(slab_width_q);
			REG_RANK_INDEX:  prdata = DATA_W'(rank_index_q);
			REG_RANK_COUNT:  prdata = DATA_W'(rank_count_q);
			REG_GHOST_WIDTH: prdata = DATA_W'(ghost_width_q);
			default:         prdata = '0;
		endcase
	end

	assign w_eff = (slab_width_q == '0) ? SW_W'(1) : slab_width_q;

	spc_bounds #(
		.CB      (CB),
		.WB      (WB),
		.QB      (QB),
		.CNT_MAX (CNT_MAX)
	) u_bounds (
		.clk     (clk),
		.gmin    (axis_min_q),
		.gmax    (axis_max_q),
		.w_eff   (w_eff),
		.rk      (rank_index_q),
		.cnt     (rank_count_q),
		.lo_q    (lo),
		.hi_q    (hi),
		.cntw_q  (cntw),
		.cntm1_q (cntm1),
		.nbr_q   (nbr)
	);

	spc_front #(
		.CB (CB),
		.WB (WB)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pos_in.valid),
		.in_ready  (pos_in.ready),
		.pos_x     (pos_in.pos_x),
		.pos_y     (pos_in.pos_y),
		.pos_z     (pos_in.pos_z),
		.axis      (split_axis_q),
		.gmin      (axis_min_q),
		.gmax      (axis_max_q),
		.ghost     (ghost_width_q),
		.cntw      (cntw),
		.lo        (lo),
		.hi        (hi),
		.nbr       (nbr),
		.out_valid (v_c[0]),
		.out_ready (r_c[0]),
		.diff_s3   (diff),
		.flags_s3  (flags_c[0])
	);

	assign rem_c[0] = {{(DW-CB){1'b0}}, diff};
	assign quo_c[0] = '0;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		spc_cell #(
			.DW    (DW),
			.QB    (QB),
			.SHIFT (QB - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[k]),
			.in_ready  (r_c[k]),
			.rem_in    (rem_c[k]),
			.quo_in    (quo_c[k]),
			.flags_in  (flags_c[k]),
			.divisor   (w_eff),
			.out_valid (v_c[k+1]),
			.out_ready (r_c[k+1]),
			.rem_q     (rem_c[k+1]),
			.quo_q     (quo_c[k+1]),
			.flags_q   (flags_c[k+1])
		);
	end

	assign res_rdy   = !res_valid_q || res_out.ready;
	assign r_c[QB]   = res_rdy;

	always_comb begin
		if (flags_c[QB].outside) begin
			owner_sel = '0;
		end else if (flags_c[QB].clamp) begin
			owner_sel = cntm1;
		end else begin
			owner_sel = quo_c[QB];
		end
	end

	assign owner_ext = {{OWN_W{1'b0}}, owner_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_rdy) begin
			res_valid_q <= v_c[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy && v_c[QB]) begin
			owner_q     <= owner_ext[OWN_W-1:0];
			res_flags_q <= flags_c[QB];
		end
	end

	assign res_out.valid          = res_valid_q;
	assign res_out.owner_slab     = owner_q;
	assign res_out.outside_domain = res_flags_q.outside;
	assign res_out.is_local       = res_flags_q.is_local;
	assign res_out.in_lower_ghost = res_flags_q.in_lower_ghost;
	assign res_out.in_upper_ghost = res_flags_q.in_upper_ghost;
	assign res_out.send_lower     = res_flags_q.send_lower;
	assign res_out.send_upper     = res_flags_q.send_upper;

endmodule

/* rtl/spc_bounds.sv */
// Slab bounds and clamp limits derived from the configuration registers.
// Two register tiers: products first, then the signed bounds. Uses spc_pkg.
module spc_bounds #(
	parameter int CB      = spc_pkg::COORD_BITS_DEF,
	parameter int WB      = CB + 3,
	parameter int QB      = 8,
	parameter int CNT_MAX = spc_pkg::MAX_SLABS_DEF
) (
	input  logic                          clk,
	input  logic [CB-1:0]                 gmin,
	input  logic [CB-1:0]                 gmax,
	input  logic [spc_pkg::SW_W-1:0]      w_eff,
	input  logic [spc_pkg::RK_W-1:0]      rk,
	input  logic [spc_pkg::CNT_W-1:0]     cnt,
	output logic signed [WB-1:0]          lo_q,
	output logic signed [WB-1:0]          hi_q,
	output logic [spc_pkg::PROD_W-1:0]    cntw_q,
	output logic [QB-1:0]                 cntm1_q,
	output spc_pkg::nbr_t                 nbr_q
);
	import spc_pkg::*;

	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(CNT_MAX);

	logic [CNT_W-1:0]       cnt_eff;
	logic [CNT_W-1:0]       cnt_m1;
	logic [CNT_W-1:0]       rk1;
	logic [RK_W+SW_W-1:0]   rkw_q;
	logic [PROD_W-1:0]      rk1w_q;
	logic                   last_q;
	logic [WB-1:0]          gmin_w;
	logic [WB-1:0]          gmax_w;

	always_comb begin
		if (cnt == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (cnt > CNT_SAT) begin
			cnt_eff = CNT_SAT;
		end else begin
			cnt_eff = cnt;
		end
	end

	assign cnt_m1 = cnt_eff - CNT_W'(1);
	assign rk1    = {1'b0, rk} + CNT_W'(1);
	assign gmin_w = {{(WB-CB){gmin[CB-1]}}, gmin};
	assign gmax_w = {{(WB-CB){gmax[CB-1]}}, gmax};

	always_ff @(posedge clk) begin
		rkw_q           <= (RK_W+SW_W)'(rk) * (RK_W+SW_W)'(w_eff);
		rk1w_q          <= PROD_W'(rk1) * PROD_W'(w_eff);
		cntw_q          <= PROD_W'(cnt_eff) * PROD_W'(w_eff);
		cntm1_q         <= cnt_m1[QB-1:0];
		last_q          <= {1'b0, rk} == cnt_m1;
		nbr_q.has_lower <= rk != '0;
		nbr_q.has_upper <= {1'b0, rk} < cnt_m1;
	end

	always_ff @(posedge clk) begin
		lo_q <= gmin_w + {{(WB-RK_W-SW_W){1'b0}}, rkw_q};
		if (last_q) begin
			hi_q <= gmax_w;
		end else begin
			hi_q <= gmin_w + {{(WB-PROD_W){1'b0}}, rk1w_q};
		end
	end

endmodule

/* rtl/spc_front.sv */
// Front pipeline: axis select, domain test and offset, then the slab and ghost
// compares. Three stages with per-stage valid and a ready chain. Uses spc_pkg.
module spc_front #(
	parameter int CB = spc_pkg::COORD_BITS_DEF,
	parameter int WB = CB + 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [CB-1:0]        pos_x,
	input  logic signed [CB-1:0]        pos_y,
	input  logic signed [CB-1:0]        pos_z,
	input  logic [spc_pkg::AXIS_W-1:0]  axis,
	input  logic [CB-1:0]               gmin,
	input  logic [CB-1:0]               gmax,
	input  logic [spc_pkg::GW_W-1:0]    ghost,
	input  logic [spc_pkg::PROD_W-1:0]  cntw,
	input  logic signed [WB-1:0]        lo,
	input  logic signed [WB-1:0]        hi,
	input  spc_pkg::nbr_t               nbr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [CB-1:0]               diff_s3,
	output spc_pkg::cls_flags_t         flags_s3
);
	import spc_pkg::*;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  rdy1, rdy2, rdy3;
	logic signed [CB-1:0]  coord_sel;
	logic signed [CB-1:0]  coord_s1;
	logic signed [WB-1:0]  coord_w, gmin_w, ghost_w, cntw_w, dwide;
	logic signed [WB-1:0]  coord_s2, cpg_s2, cmg_s2;
	logic [CB-1:0]         diff_s2;
	logic                  outside_s2, clamp_s2;

	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = valid_s3;

	always_comb begin
		unique case (axis)
			AXIS_X:  coord_sel = pos_x;
			AXIS_Y:  coord_sel = pos_y;
			default: coord_sel = pos_z;
		endcase
	end

	assign coord_w = {{(WB-CB){coord_s1[CB-1]}}, coord_s1};
	assign gmin_w  = {{(WB-CB){gmin[CB-1]}}, gmin};
	assign ghost_w = {{(WB-GW_W){1'b0}}, ghost};
	assign cntw_w  = {{(WB-PROD_W){1'b0}}, cntw};
	assign dwide   = coord_w - gmin_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			coord_s1 <= coord_sel;
		end
		if (rdy2 && valid_s1) begin
			coord_s2   <= coord_w;
			cpg_s2     <= coord_w + ghost_w;
			cmg_s2     <= coord_w - ghost_w;
			diff_s2    <= dwide[CB-1:0];
			outside_s2 <= (coord_s1 < $signed(gmin)) || (coord_s1 >= $signed(gmax));
			clamp_s2   <= dwide >= cntw_w;
		end
		if (rdy3 && valid_s2) begin
			diff_s3                 <= diff_s2;
			flags_s3.outside        <= outside_s2;
			flags_s3.clamp          <= clamp_s2;
			flags_s3.is_local       <= (coord_s2 >= lo) && (coord_s2 < hi);
			flags_s3.in_lower_ghost <= nbr.has_lower && (cpg_s2 >= lo) && (coord_s2 < lo);
			flags_s3.in_upper_ghost <= nbr.has_upper && (coord_s2 >= hi) && (cmg_s2 < hi);
			flags_s3.send_lower     <= nbr.has_lower && (cmg_s2 < lo);
			flags_s3.send_upper     <= nbr.has_upper && (cpg_s2 >= hi);
		end
	end

endmodule

/* rtl/spc_cell.sv */
// One restoring-division cell: settles one quotient bit and passes the partial
// remainder, quotient and flags to the next cell. Uses spc_pkg.
module spc_cell #(
	parameter int DW    = 41,
	parameter int QB    = 8,
	parameter int SHIFT = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [DW-1:0]            rem_in,
	input  logic [QB-1:0]            quo_in,
	input  spc_pkg::cls_flags_t      flags_in,
	input  logic [spc_pkg::SW_W-1:0] divisor,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DW-1:0]            rem_q,
	output logic [QB-1:0]            quo_q,
	output spc_pkg::cls_flags_t      flags_q
);
	import spc_pkg::*;

	logic          valid_q;
	logic          take;
	logic [DW-1:0] dsh;
	logic [DW-1:0] rem_next;
	logic [QB-1:0] quo_next;

	assign dsh      = {{(DW-SW_W){1'b0}}, divisor} << SHIFT;
	assign take     = rem_in >= dsh;
	assign rem_next = take ? rem_in - dsh : rem_in;

	always_comb begin
		quo_next        = quo_in;
		quo_next[SHIFT] = take;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q   <= rem_next;
			quo_q   <= quo_next;
			flags_q <= flags_in;
		end
	end

endmodule

/* rtl/spc_checker.sv */
// Port-level checks of the classifier result stream, bound to the top level.
// Depends on spc_pkg and slab_particle_classifier_unit.
module spc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [spc_pkg::OWN_W-1:0] owner_slab,
	input logic                      outside_domain,
	input logic                      is_local,
	input logic                      in_lower_ghost,
	input logic                      in_upper_ghost,
	input logic                      send_lower,
	input logic                      send_upper
);
	import spc_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(owner_slab)
			&& $stable(outside_domain) && $stable(is_local)
			&& $stable(in_lower_ghost) && $stable(in_upper_ghost)
			&& $stable(send_lower) && $stable(send_upper))
		else $error("result beat changed while stalled");

	a_outside_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside_domain |-> owner_slab == '0)
		else $error("owner slab nonzero for a position outside the domain");

	a_local_not_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_local |-> !in_lower_ghost && !in_upper_ghost)
		else $error("position flagged both local and in a ghost band");

	a_ghost_sends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!in_lower_ghost || send_lower) && (!in_upper_ghost || send_upper))
		else $error("ghost band beat without the matching send flag");

endmodule

bind slab_particle_classifier_unit spc_checker u_spc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (res_out.valid),
	.out_ready      (res_out.ready),
	.owner_slab     (res_out.owner_slab),
	.outside_domain (res_out.outside_domain),
	.is_local       (res_out.is_local),
	.in_lower_ghost (res_out.in_lower_ghost),
	.in_upper_ghost (res_out.in_upper_ghost),
	.send_lower     (res_out.send_lower),
	.send_upper     (res_out.send_upper)
);
